// File: src/fps_pkg.sv
// shared constants, codes and transaction types for the free page stack
`timescale 1ns / 1ps
`default_nettype none
package fps_pkg;

  localparam int PAGE_W    = 20;
  localparam int COUNT_W   = 11;
  localparam int CAP_W     = 11;
  localparam int STATUS_W  = 2;

  localparam int DEPTH_DEF     = 1024;
  localparam int PAGE_BITS_DEF = 20;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              command;
    logic [PAGE_W-1:0] page_number;
  } cmd_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   page_out;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
  } res_t;

endpackage
`default_nettype wire

// File: src/free_page_stack.sv
// free page stack: lifo allocator of physical page numbers
// a command is held in the input register, its result then in the result register (2 stages)
// throughput: one command per cycle while the result is not stalled, set by the cached
//   top entry and the prefetched second entry read from the page memory each cycle
// reset: stack count cleared, capacity set to 1024, both stages empty; page memory not cleared
`timescale 1ns / 1ps
`default_nettype none
module free_page_stack #(
  parameter int DEPTH     = fps_pkg::DEPTH_DEF,
  parameter int PAGE_BITS = fps_pkg::PAGE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [19:0] page_number_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [19:0]      page_out_o,
  output logic [1:0]       status_o,
  output logic [10:0]      free_count_o,
  // capacity register write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [10:0] cfg_pool_capacity_i
);
  import fps_pkg::*;

  logic             stage_valid;
  logic             advance;
  logic             exec;
  cmd_t             stage_cmd;
  res_t             stage_res;
  logic [CAP_W-1:0] capacity_q;

  // capacity reg, always ready; sender must write it only with no command in flight (unenforced)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_pool_capacity_i;
    end
  end

  // input stage
  fps_in_reg u_in_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .page_number_i (page_number_i),
    .advance_i     (advance),
    .valid_o       (stage_valid),
    .cmd_o         (stage_cmd)
  );

  // the held command executes when the result register can take its result
  assign exec = stage_valid && advance;

  fps_stack #(
    .DEPTH     (DEPTH),
    .PAGE_BITS (PAGE_BITS)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .exec_i     (exec),
    .cmd_i      (stage_cmd),
    .capacity_i (capacity_q),
    .res_o      (stage_res)
  );

  // result stage
  fps_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (exec),
    .res_i        (stage_res),
    .advance_o    (advance),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .page_out_o   (page_out_o),
    .status_o     (status_o),
    .free_count_o (free_count_o)
  );

  // a failed command never hands out a page
  a_fail_no_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> page_out_o == '0)
    else $error("failed command returned a page");

  // an empty report means nothing is left on the stack
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> free_count_o == '0)
    else $error("empty status with nonzero free count");

  // status carries only the three defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK) || (status_o == ST_EMPTY) || (status_o == ST_FULL))
    else $error("undefined status code");

  // the command side only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule
`default_nettype wire

// File: src/fps_in_reg.sv
// input register stage holding one command transaction
`timescale 1ns / 1ps
`default_nettype none
module fps_in_reg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  command_i,
  input  wire logic [19:0]           page_number_i,
  input  wire logic                  advance_i,
  output logic                       valid_o,
  output fps_pkg::cmd_t              cmd_o
);
  import fps_pkg::*;

  logic valid_q, valid_d;
  logic load;
  cmd_t cmd_q;

  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q.command     <= command_i;
      cmd_q.page_number <= page_number_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule
`default_nettype wire

// File: src/fps_stack.sv
// stack storage, count, cached top entry and per-command result logic
`timescale 1ns / 1ps
`default_nettype none
module fps_stack #(
  parameter int DEPTH     = fps_pkg::DEPTH_DEF,
  parameter int PAGE_BITS = fps_pkg::PAGE_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       exec_i,
  input  wire fps_pkg::cmd_t              cmd_i,
  input  wire logic [fps_pkg::CAP_W-1:0]  capacity_i,
  output fps_pkg::res_t                   res_o
);
  import fps_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [PAGE_BITS-1:0] page_mem [DEPTH];

  logic [CNT_W-1:0]     count_q, count_d;
  logic [PAGE_BITS-1:0] top_q, top_d;
  logic [PAGE_BITS-1:0] second_q;
  logic [CNT_W-1:0]     rd_cnt;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 full, empty, push, pop;

  // full when the count reaches the programmed capacity or the built depth
  assign full  = (CMP_W'(count_q) >= CMP_W'(capacity_i)) || (count_q >= CNT_W'(DEPTH));
  assign empty = (count_q == '0);
  assign push  = exec_i && (cmd_i.command == CMD_FREE) && !full;
  assign pop   = exec_i && (cmd_i.command == CMD_ALLOC) && !empty;

  assign wr_addr = count_q[IDX_W-1:0];

  always_comb begin
    count_d = count_q;
    top_d   = top_q;
    if (push) begin
      count_d = count_q + CNT_W'(1);
      top_d   = PAGE_BITS'(cmd_i.page_number);
    end else if (pop) begin
      count_d = count_q - CNT_W'(1);
      top_d   = second_q;
    end
  end

  // prefetch the entry below the next top so a pop can follow a pop
  assign rd_cnt  = (count_d >= CNT_W'(2)) ? (count_d - CNT_W'(2)) : '0;
  assign rd_addr = rd_cnt[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      page_mem[wr_addr] <= PAGE_BITS'(cmd_i.page_number);
    end
    second_q <= page_mem[rd_addr];
  end

  always_comb begin
    res_o.page_out   = '0;
    res_o.status     = ST_OK;
    res_o.free_count = COUNT_W'(count_d);
    if (cmd_i.command == CMD_FREE) begin
      if (full) begin
        res_o.status = ST_FULL;
      end
    end else begin
      if (empty) begin
        res_o.status = ST_EMPTY;
      end else begin
        res_o.page_out = PAGE_W'(top_q);
      end
    end
  end

endmodule
`default_nettype wire

// File: src/fps_out_reg.sv
// result register with stall handling toward the consumer
`timescale 1ns / 1ps
`default_nettype none
module fps_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire fps_pkg::res_t res_i,
  output logic               advance_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [19:0]        page_out_o,
  output logic [1:0]         status_o,
  output logic [10:0]        free_count_o
);
  import fps_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign advance_o = !valid_q || !out_stall_i;
  assign valid_d   = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign page_out_o   = res_q.page_out;
  assign status_o     = res_q.status;
  assign free_count_o = res_q.free_count;

endmodule
`default_nettype wire
